### hdl/rlab_pkg.sv
// Shared types and fixed constants for the RGB to l-alpha-beta converter.
// No dependencies; used by rlab_log10 and rgb_to_lalphabeta_convert.

package rlab_pkg;

    localparam int CHAN_W = 8;     // input colour channel
    localparam int ACC_W  = 20;    // Q0.12 coefficient times channel, summed
    localparam int LMS_W  = 16;    // unsigned Q8.8
    localparam int MSB_W  = 4;     // leading-one position of an LMS value
    localparam int FRAC_W = 15;    // mantissa fraction below the leading one
    localparam int MANT_W = 16;    // log2 mantissa, Q0.16
    localparam int L2_W   = 20;    // signed log2, Q4.16
    localparam int L2P_W  = 36;    // log2 times the log10(2) factor
    localparam int LOG_W  = 19;    // signed log10, Q.16
    localparam int SUM_W  = 21;    // sum of three logs
    localparam int PROD_W = 36;    // Q.30 combination product
    localparam int OUT_W  = 16;    // signed result

    typedef logic [CHAN_W-1:0]        chan_t;
    typedef logic [LMS_W-1:0]         lms_t;
    typedef logic signed [LOG_W-1:0]  log_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [OUT_W-1:0]  res_t;

    // RGB to LMS matrix, Q0.12, row major (L, M, S rows; R, G, B columns)
    localparam logic [11:0] LMS_COEF [3][3] = '{
        '{12'd1561, 12'd2369, 12'd165},
        '{12'd806,  12'd2967, 12'd320},
        '{12'd99,   12'd528,  12'd3459}
    };

    // log10(2) in Q0.16
    localparam logic signed [15:0] LOG10_2 = 16'sd19728;

    // Combination coefficients, Q1.14
    localparam logic signed [15:0] L_COEF  = 16'sd9458;
    localparam logic signed [15:0] A_COEF  = 16'sd6688;
    localparam logic signed [15:0] AS_COEF = 16'sd13376;
    localparam logic signed [15:0] B_COEF  = 16'sd11585;

    localparam logic signed [OUT_W-1:0] RES_MAX = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0] RES_MIN = 16'sh8000;

endpackage

### hdl/rgb_to_lalphabeta_convert.sv
// Top level of the RGB to l-alpha-beta converter: input register, LMS matrix,
// three log10 units, combination and output rounding. Depends on rlab_pkg, rlab_log10.
//
// Usage:
//   Input channel in_valid/in_ready carries one RGB pixel per beat (red,
//   green, blue, 8 bits each). Output channel out_valid/out_ready carries
//   lightness, alpha_chroma and beta_chroma, signed with OUT_FRAC_BITS
//   fraction bits (Q4.12 by default), saturated to 16 bits.
//   From the accepting edge, which loads the input register, a pixel passes
//   through LMS, four log10 stages, combination products and the rounding
//   output register to out_valid.
//   One pixel is taken every clock while in_ready is high.
//   Each stage holds its own valid bit and loads when it is empty or its
//   successor moves, so a stalled receiver only freezes the stages that are
//   full; bubbles ahead of the stall still fill and in_ready stays high until
//   every stage holds a pixel. Nothing is dropped or repeated.
//   Reset clears all valid bits; the pipe is empty and ready afterwards.
//   A black pixel gives zero on all three outputs.

module rgb_to_lalphabeta_convert #(
    parameter int LOG_TABLE_ENTRIES = 256,
    parameter int OUT_FRAC_BITS     = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rlab_pkg::chan_t         red,
    input  rlab_pkg::chan_t         green,
    input  rlab_pkg::chan_t         blue,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rlab_pkg::res_t          lightness,
    output rlab_pkg::res_t          alpha_chroma,
    output rlab_pkg::res_t          beta_chroma
);

    localparam int NSTAGE = 8;
    localparam int SHIFT  = 30 - OUT_FRAC_BITS;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE:0]   rdy;

    // a stage loads when empty or when its successor takes its beat
    always_comb
    begin
        rdy[NSTAGE] = out_ready;
        for (int k = NSTAGE - 1; k >= 0; k--)
            rdy[k] = ~valid_reg[k] | rdy[k+1];
        for (int k = 0; k < NSTAGE; k++)
        begin
            if (!rdy[k])
                valid_next[k] = valid_reg[k];
            else if (k == 0)
                valid_next[k] = in_valid;
            else
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NSTAGE-1];

    // stage 0: input register
    rlab_pkg::chan_t rgb_reg [3];

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            rgb_reg[0] <= red;
            rgb_reg[1] <= green;
            rgb_reg[2] <= blue;
        end
    end

    // stage 1: LMS = (M * rgb + 8) >> 4
    logic [rlab_pkg::ACC_W-1:0] acc [3];
    rlab_pkg::lms_t             lms_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc[r] = rlab_pkg::ACC_W'(8);
            for (int c = 0; c < 3; c++)
                acc[r] = acc[r] + rlab_pkg::ACC_W'(rlab_pkg::LMS_COEF[r][c])
                                * rlab_pkg::ACC_W'(rgb_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            for (int r = 0; r < 3; r++)
                lms_reg[r] <= acc[r][4 +: rlab_pkg::LMS_W];
        end
    end

    // stages 2 to 5: log10 of each LMS value
    rlab_pkg::log_t log_val [3];

    for (genvar r = 0; r < 3; r++)
    begin : g_log
        rlab_log10 #(
            .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
        ) u_log (
            .clk     (clk),
            .load    (rdy[5:2]),
            .lms     (lms_reg[r]),
            .log_val (log_val[r])
        );
    end

    // stage 6: combination products, Q.30
    logic signed [rlab_pkg::SUM_W-1:0] sum_lms;
    logic signed [rlab_pkg::SUM_W-1:0] sum_lm;
    logic signed [rlab_pkg::SUM_W-1:0] diff_lm;
    rlab_pkg::prod_t                   l_prod_reg;
    rlab_pkg::prod_t                   a_prod_reg;
    rlab_pkg::prod_t                   b_prod_reg;

    assign sum_lm  = rlab_pkg::SUM_W'(log_val[0]) + rlab_pkg::SUM_W'(log_val[1]);
    assign sum_lms = sum_lm + rlab_pkg::SUM_W'(log_val[2]);
    assign diff_lm = rlab_pkg::SUM_W'(log_val[0]) - rlab_pkg::SUM_W'(log_val[1]);

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            l_prod_reg <= rlab_pkg::PROD_W'(sum_lms) * rlab_pkg::PROD_W'(rlab_pkg::L_COEF);
            a_prod_reg <= rlab_pkg::PROD_W'(sum_lm) * rlab_pkg::PROD_W'(rlab_pkg::A_COEF)
                        - rlab_pkg::PROD_W'(log_val[2]) * rlab_pkg::PROD_W'(rlab_pkg::AS_COEF);
            b_prod_reg <= rlab_pkg::PROD_W'(diff_lm) * rlab_pkg::PROD_W'(rlab_pkg::B_COEF);
        end
    end

    // stage 7: round half up, saturate, output register
    function automatic rlab_pkg::res_t round_sat(input rlab_pkg::prod_t p);
        rlab_pkg::prod_t t;
        t = (p + (rlab_pkg::PROD_W'(1) <<< (SHIFT - 1))) >>> SHIFT;
        if (t > rlab_pkg::PROD_W'(rlab_pkg::RES_MAX))
            return rlab_pkg::RES_MAX;
        else if (t < rlab_pkg::PROD_W'(rlab_pkg::RES_MIN))
            return rlab_pkg::RES_MIN;
        else
            return t[rlab_pkg::OUT_W-1:0];
    endfunction

    rlab_pkg::res_t l_reg;
    rlab_pkg::res_t a_reg;
    rlab_pkg::res_t b_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            l_reg <= round_sat(l_prod_reg);
            a_reg <= round_sat(a_prod_reg);
            b_reg <= round_sat(b_prod_reg);
        end
    end

    assign lightness    = l_reg;
    assign alpha_chroma = a_reg;
    assign beta_chroma  = b_reg;

endmodule

### hdl/rlab_log10.sv
// Four-stage pipelined log10 of one unsigned Q8.8 LMS value, result signed Q.16.
// Leading-one search, table index, mantissa table read, log10(2) scaling.
// Depends on rlab_pkg.

module rlab_log10 #(
    parameter int LOG_TABLE_ENTRIES = 256
) (
    input  logic                clk,
    input  logic [3:0]          load,
    input  rlab_pkg::lms_t      lms,
    output rlab_pkg::log_t      log_val
);

    localparam int IDX_W = $clog2(LOG_TABLE_ENTRIES);
    localparam int IP_W  = rlab_pkg::FRAC_W + IDX_W + 1;

    // log2(1 + idx/N) in Q0.16 by repeated squaring; evaluated at elaboration only
    function automatic logic [rlab_pkg::MANT_W-1:0] mant_log2(input int unsigned idx);
        logic [63:0] x;
        logic [rlab_pkg::MANT_W-1:0] y;
        int b;
        x = (64'(1) << 30) + ((64'(idx) << 30) / LOG_TABLE_ENTRIES);
        y = '0;
        for (b = 1; b <= 16; b++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'(1) << 31))
            begin
                x = x >> 1;
                y[4'(16 - b)] = 1'b1;
            end
        end
        return y;
    endfunction

    logic [rlab_pkg::MANT_W-1:0] mant_tab [LOG_TABLE_ENTRIES];

    for (genvar i = 0; i < LOG_TABLE_ENTRIES; i++)
    begin : g_tab
        assign mant_tab[i] = mant_log2(i);
    end

    // leading-one search and normalise
    logic [rlab_pkg::MSB_W-1:0]  msb_next;
    logic [rlab_pkg::LMS_W-1:0]  norm;
    logic [rlab_pkg::MSB_W-1:0]  msb2_reg;
    logic [rlab_pkg::FRAC_W-1:0] frac_reg;
    logic                        zero2_reg;

    always_comb
    begin
        msb_next = '0;
        for (int i = 0; i < rlab_pkg::LMS_W; i++)
        begin
            if (lms[i])
                msb_next = rlab_pkg::MSB_W'(i);
        end
        norm = lms << (4'd15 - msb_next);
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            msb2_reg  <= msb_next;
            frac_reg  <= norm[rlab_pkg::FRAC_W-1:0];
            zero2_reg <= (lms == '0);
        end
    end

    // table index = floor(frac * N / 2^15)
    logic [IP_W-1:0]             idx_prod;
    logic [IDX_W-1:0]            idx_reg;
    logic [rlab_pkg::MSB_W-1:0]  msb3_reg;
    logic                        zero3_reg;

    assign idx_prod = IP_W'(frac_reg) * IP_W'(LOG_TABLE_ENTRIES);

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            idx_reg   <= idx_prod[rlab_pkg::FRAC_W +: IDX_W];
            msb3_reg  <= msb2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // log2: integer part msb - 8 is the msb code with its top bit flipped
    logic signed [rlab_pkg::L2_W-1:0] l2_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            if (zero3_reg)
                l2_reg <= '0;
            else
                l2_reg <= {~msb3_reg[3], msb3_reg[2:0], mant_tab[idx_reg]};
        end
    end

    // log10 = round(log2 * 19728 / 2^16)
    logic signed [rlab_pkg::L2P_W-1:0] l2_prod;
    rlab_pkg::log_t                    log_reg;

    assign l2_prod = rlab_pkg::L2P_W'(l2_reg) * rlab_pkg::L2P_W'(rlab_pkg::LOG10_2)
                     + rlab_pkg::L2P_W'(32768);

    always_ff @(posedge clk)
    begin
        if (load[3])
            log_reg <= l2_prod[16 +: rlab_pkg::LOG_W];
    end

    assign log_val = log_reg;

endmodule
